/* rtl/ppi_kmp_pkg.sv */
// shared types and constants of the keyboard and mouse port block
`timescale 1ns / 1ps

package ppi_kmp_pkg;

   localparam int DEF_KEY_ROWS = 8;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_KEY   = 2'd2;
   localparam logic [1:0] KIND_MOUSE = 2'd3;

   localparam logic [1:0] PORT_A    = 2'd0;
   localparam logic [1:0] PORT_B    = 2'd1;
   localparam logic [1:0] PORT_C    = 2'd2;
   localparam logic [1:0] PORT_CTRL = 2'd3;

   localparam logic [7:0] CTRL_MOUSE = 8'h80;
   localparam logic [7:0] CTRL_KEYS  = 8'h8A;
   localparam int         CTRL_MODE_BIT = 7;

   localparam logic [7:0] RESET_A    = 8'hFF;
   localparam logic [7:0] RESET_B    = 8'hFF;
   localparam logic [7:0] RESET_C    = 8'hE0;
   localparam logic [7:0] RESET_CTRL = 8'h8A;
   localparam logic [7:0] RESET_ROW  = 8'hFF;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [1:0]         port_sel;
      logic [7:0]         write_data;
      logic [2:0]         key_row;
      logic [7:0]         row_bits;
      logic signed [15:0] mouse_x_pos;
      logic signed [15:0] mouse_y_pos;
      logic [7:0]         mouse_keys;
   } req_item_type;

   typedef struct packed {
      logic [7:0] ctrl_image;
      logic [7:0] c_image;
      logic [7:0] b_image;
      logic [7:0] a_image;
   } rsp_item_type;

   typedef struct packed {
      logic       en;
      logic [2:0] row;
      logic [7:0] bits;
   } key_wr_type;

endpackage

/* rtl/ppi_kmp_keys.sv */
// key matrix rows and the and of the rows selected by port A
`timescale 1ns / 1ps

module ppi_kmp_keys
   import ppi_kmp_pkg::*;
#(
   parameter int KEY_ROWS = DEF_KEY_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  key_wr_type wr,
   input  logic [7:0] sel_mask,
   output logic [7:0] and_out
);

   logic [7:0] rows_ff [KEY_ROWS];

   // a row index beyond the matrix matches no row and is dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (reset) begin
            rows_ff[i] <= RESET_ROW;
         end else if (wr.en && (wr.row == 3'(i))) begin
            rows_ff[i] <= wr.bits;
         end
      end
   end

   // zero bits of the mask select rows
   always_comb begin
      and_out = 8'hFF;
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (!sel_mask[i]) begin
            and_out = and_out & rows_ff[i];
         end
      end
   end

endmodule

/* rtl/ppi_kmp_exec.sv */
// port registers, mode, mouse state and refresh of the port image
`timescale 1ns / 1ps

module ppi_kmp_exec
   import ppi_kmp_pkg::*;
#(
   parameter int KEY_ROWS = DEF_KEY_ROWS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  req_item_type item,
   output logic         hit,
   output rsp_item_type result
);

   logic [7:0] a_ff, b_ff, c_ff, ctrl_ff;
   logic [7:0] a_in, b_in, c_in, ctrl_in;
   logic [7:0] sa_ff, sb_ff, sc_ff;
   logic [7:0] sa_in, sb_in, sc_in;
   logic       kbd_ff, kbd_in;
   // only the low byte of a position ever reaches a port
   logic [7:0] cx_ff, cy_ff, lx_ff, ly_ff, btn_ff;
   logic [7:0] cx_in, cy_in, lx_in, ly_in, btn_in;
   logic       refresh;
   key_wr_type key_wr;
   logic [7:0] key_sel;
   logic [7:0] key_and;

   // port A as the keyboard refresh sees it, kept apart from the main update
   always_comb begin
      key_sel = a_ff;
      if (item.req_type == KIND_WRITE) begin
         if (item.port_sel == PORT_A) begin
            key_sel = item.write_data;
         end else if ((item.port_sel == PORT_CTRL) && (item.write_data == CTRL_KEYS)) begin
            key_sel = sa_ff;
         end
      end
   end

   ppi_kmp_keys #(
      .KEY_ROWS(KEY_ROWS)
   ) u_keys (
      .clock   (clock),
      .reset   (reset),
      .wr      (key_wr),
      .sel_mask(key_sel),
      .and_out (key_and)
   );

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      ctrl_in = ctrl_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      sc_in   = sc_ff;
      kbd_in  = kbd_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      lx_in   = lx_ff;
      ly_in   = ly_ff;
      btn_in  = btn_ff;
      refresh = 1'b0;
      key_wr.en   = go && (item.req_type == KIND_KEY);
      key_wr.row  = item.key_row;
      key_wr.bits = item.row_bits;

      case (item.req_type)
         KIND_WRITE: begin
            case (item.port_sel)
               PORT_A: begin
                  a_in    = item.write_data;
                  refresh = 1'b1;
               end
               PORT_B: b_in = item.write_data;
               PORT_C: c_in = item.write_data;
               default: begin
                  ctrl_in = item.write_data;
                  if (item.write_data == CTRL_MOUSE) begin
                     sa_in   = a_ff;
                     sb_in   = b_ff;
                     sc_in   = c_ff;
                     kbd_in  = 1'b0;
                     refresh = 1'b1;
                  end else if (item.write_data == CTRL_KEYS) begin
                     a_in    = sa_ff;
                     b_in    = sb_ff;
                     c_in    = sc_ff;
                     kbd_in  = 1'b1;
                     refresh = 1'b1;
                  end else if (kbd_ff && !item.write_data[CTRL_MODE_BIT]) begin
                     // bit set/reset of port C
                     c_in[item.write_data[3:1]] = item.write_data[0];
                  end
               end
            endcase
         end
         KIND_READ: begin
            if (!kbd_ff) begin
               if (item.port_sel == PORT_A) begin
                  lx_in   = cx_ff;
                  refresh = 1'b1;
               end else if (item.port_sel == PORT_B) begin
                  ly_in   = cy_ff;
                  refresh = 1'b1;
               end
            end else if (item.port_sel == PORT_C) begin
               refresh = 1'b1;
            end
         end
         KIND_MOUSE: begin
            cx_in  = item.mouse_x_pos[7:0];
            cy_in  = item.mouse_y_pos[7:0];
            btn_in = item.mouse_keys;
         end
         default: ;
      endcase

      if (refresh) begin
         if (!kbd_in) begin
            a_in = cx_in - lx_in;
            b_in = cy_in - ly_in;
            c_in = btn_in;
         end else begin
            b_in = key_and;
         end
      end
   end

   assign hit               = refresh;
   assign result.ctrl_image = ctrl_in;
   assign result.c_image    = c_in;
   assign result.b_image    = b_in;
   assign result.a_image    = a_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= RESET_A;
         b_ff    <= RESET_B;
         c_ff    <= RESET_C;
         ctrl_ff <= RESET_CTRL;
         sa_ff   <= RESET_A;
         sb_ff   <= RESET_B;
         sc_ff   <= RESET_C;
         kbd_ff  <= 1'b1;
         cx_ff   <= '0;
         cy_ff   <= '0;
         lx_ff   <= '0;
         ly_ff   <= '0;
         btn_ff  <= '0;
      end else if (go) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         ctrl_ff <= ctrl_in;
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         sc_ff   <= sc_in;
         kbd_ff  <= kbd_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         btn_ff  <= btn_in;
      end
   end

`ifndef SYNTHESIS
   a_mouse_mode: assert property (@(posedge clock) disable iff (reset)
      go && (item.req_type == KIND_WRITE) && (item.port_sel == PORT_CTRL)
         && (item.write_data == CTRL_MOUSE) |=> !kbd_ff)
      else $error("mouse mode not entered");
   a_keys_mode: assert property (@(posedge clock) disable iff (reset)
      go && (item.req_type == KIND_WRITE) && (item.port_sel == PORT_CTRL)
         && (item.write_data == CTRL_KEYS) |=> kbd_ff && (a_ff == $past(sa_ff)))
      else $error("keyboard mode restore failed");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(a_ff) && $stable(c_ff) && $stable(kbd_ff))
      else $error("port state changed without a transaction");
`endif

endmodule

/* rtl/ppi_kmp_port_core.sv */
// keyboard and mouse parallel port: input register, execute stage, result register
// flow: a transaction passes from the input register through the execute stage, and a refresh
// loads its port image into the result register
// throughput: one transaction per cycle while the result side does not stall, set by the single execute stage
// the execute stage holds while a result waits stalled in the result register
// reset: synchronous, restores the port registers and mode, and sets every key matrix row to all ones
`timescale 1ns / 1ps

module ppi_keyboard_mouse_port_core
   import ppi_kmp_pkg::*;
#(
   parameter int KEY_ROWS = DEF_KEY_ROWS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;
   logic         exec_go;
   logic         exec_hit;
   rsp_item_type exec_result;

   assign exec_go   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec_go;

   ppi_kmp_exec #(
      .KEY_ROWS(KEY_ROWS)
   ) u_exec (
      .clock (clock),
      .reset (reset),
      .go    (exec_go),
      .item  (in_item_ff),
      .hit   (exec_hit),
      .result(exec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (exec_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= exec_hit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && exec_hit) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stage empty but stalling");
   a_hit_shows: assert property (@(posedge clock) disable iff (reset)
      exec_go && exec_hit |=> rsp_valid_ff && (rsp_data_ff == $past(exec_result)))
      else $error("refresh result lost");
   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !exec_go |=> in_valid_ff && (in_item_ff == $past(in_item_ff)))
      else $error("stalled transaction dropped");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the keyboard and mouse parallel port core
module tb_top;
   import ppi_kmp_pkg::*;

   class port_scoreboard;
      logic [7:0]   port_a, port_b, port_c, ctrl_reg;
      logic [7:0]   keep_a, keep_b, keep_c;
      bit           kbd_mode;
      logic [7:0]   key_rows [DEF_KEY_ROWS];
      logic [15:0]  pos_x, pos_y, seen_x, seen_y;
      logic [7:0]   btn_bits;
      rsp_item_type pending_images [$];
      int           errors;
      int           compared;
      int           mode_writes;

      function new();
         port_a   = RESET_A;
         port_b   = RESET_B;
         port_c   = RESET_C;
         ctrl_reg = RESET_CTRL;
         keep_a   = RESET_A;
         keep_b   = RESET_B;
         keep_c   = RESET_C;
         kbd_mode = 1'b1;
         foreach (key_rows[i]) key_rows[i] = RESET_ROW;
         pos_x    = '0;
         pos_y    = '0;
         seen_x   = '0;
         seen_y   = '0;
         btn_bits = '0;
         errors   = 0;
         compared = 0;
         mode_writes = 0;
      endfunction

      // recompute the port image and queue it as the next expected transaction
      function void post_image();
         logic [15:0]  dx, dy;
         logic [7:0]   acc;
         rsp_item_type img;
         if (!kbd_mode) begin
            dx = pos_x - seen_x;
            dy = pos_y - seen_y;
            port_a = dx[7:0];
            port_b = dy[7:0];
            port_c = btn_bits;
         end else begin
            acc = 8'hFF;
            for (int i = 0; i < DEF_KEY_ROWS; i++) begin
               if (!port_a[i]) acc &= key_rows[i];
            end
            port_b = acc;
         end
         img.ctrl_image = ctrl_reg;
         img.c_image    = port_c;
         img.b_image    = port_b;
         img.a_image    = port_a;
         pending_images.push_back(img);
      endfunction

      function void note_request(input req_item_type r);
         case (r.req_type)
            KIND_WRITE: begin
               case (r.port_sel)
                  PORT_A: begin
                     port_a = r.write_data;
                     post_image();
                  end
                  PORT_B: port_b = r.write_data;
                  PORT_C: port_c = r.write_data;
                  default: begin
                     ctrl_reg = r.write_data;
                     if (r.write_data == CTRL_MOUSE) begin
                        keep_a = port_a;
                        keep_b = port_b;
                        keep_c = port_c;
                        kbd_mode = 1'b0;
                        mode_writes++;
                        post_image();
                     end else if (r.write_data == CTRL_KEYS) begin
                        port_a = keep_a;
                        port_b = keep_b;
                        port_c = keep_c;
                        kbd_mode = 1'b1;
                        mode_writes++;
                        post_image();
                     end else if (kbd_mode && !r.write_data[CTRL_MODE_BIT]) begin
                        // bit set/reset on port c
                        port_c[r.write_data[3:1]] = r.write_data[0];
                     end
                  end
               endcase
            end
            KIND_READ: begin
               if (!kbd_mode) begin
                  if (r.port_sel == PORT_A) begin
                     seen_x = pos_x;
                     post_image();
                  end else if (r.port_sel == PORT_B) begin
                     seen_y = pos_y;
                     post_image();
                  end
               end else if (r.port_sel == PORT_C) begin
                  post_image();
               end
            end
            KIND_KEY: begin
               if (r.key_row < DEF_KEY_ROWS) key_rows[r.key_row] = r.row_bits;
            end
            default: begin
               pos_x    = r.mouse_x_pos;
               pos_y    = r.mouse_y_pos;
               btn_bits = r.mouse_keys;
            end
         endcase
      endfunction

      function void check_image(input rsp_item_type got);
         rsp_item_type want;
         if (pending_images.size() == 0) begin
            errors++;
            $display("%0t: unexpected image, expected none, actual %h", $time, got);
            return;
         end
         want = pending_images.pop_front();
         compared++;
         if (got.ctrl_image !== want.ctrl_image) begin
            errors++;
            $display("%0t: ctrl_image expected %h actual %h", $time,
                     want.ctrl_image, got.ctrl_image);
         end
         if (got.c_image !== want.c_image) begin
            errors++;
            $display("%0t: c_image expected %h actual %h", $time, want.c_image, got.c_image);
         end
         if (got.b_image !== want.b_image) begin
            errors++;
            $display("%0t: b_image expected %h actual %h", $time, want.b_image, got.b_image);
         end
         if (got.a_image !== want.a_image) begin
            errors++;
            $display("%0t: a_image expected %h actual %h", $time, want.a_image, got.a_image);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   port_scoreboard sb;
   bit             quiet = 1'b0;
   bit             hold_rsp = 1'b0;
   int             n_sent = 0;

   ppi_keyboard_mouse_port_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic req_item_type random_item();
      logic [63:0]  raw;
      req_item_type it;
      raw = {$urandom, $urandom};
      it = raw[$bits(req_item_type)-1:0];
      return it;
   endfunction

   function automatic req_item_type make_item(input logic [1:0] kind, input logic [1:0] port,
                                              input logic [7:0] data, input logic [2:0] row);
      req_item_type it;
      it = random_item();
      it.req_type   = kind;
      it.port_sel   = port;
      it.write_data = data;
      it.row_bits   = data;
      it.key_row    = row;
      return it;
   endfunction

   // mostly well-formed keyboard and mouse traffic, shaped by the current mode
   function automatic req_item_type pick_item(input bit fill_burst);
      req_item_type it;
      int           roll;
      it = random_item();
      roll = fill_burst ? 55 : $urandom_range(99);
      if (roll < 6) begin
         it.req_type = KIND_WRITE;
         it.port_sel = PORT_CTRL;
         it.write_data = (sb.kbd_mode ^ ($urandom_range(4) == 0)) ? CTRL_MOUSE : CTRL_KEYS;
      end else if (roll < 20) begin
         it.req_type = KIND_KEY;
         if ($urandom_range(1)) it.row_bits = ~(8'h01 << $urandom_range(7));
      end else if (roll < 32) begin
         it.req_type = KIND_MOUSE;
      end else if (roll < 50) begin
         it.req_type = KIND_READ;
         if (!sb.kbd_mode && $urandom_range(3) != 0)
            it.port_sel = $urandom_range(1) ? PORT_A : PORT_B;
         else if (sb.kbd_mode && $urandom_range(1))
            it.port_sel = PORT_C;
      end else if (roll < 62) begin
         it.req_type = KIND_WRITE;
         it.port_sel = PORT_A;
         if ($urandom_range(1)) it.write_data = ~(8'h01 << $urandom_range(7));
      end else if (roll < 70) begin
         it.req_type = KIND_WRITE;
         it.port_sel = $urandom_range(1) ? PORT_B : PORT_C;
      end else if (roll < 80) begin
         it.req_type = KIND_WRITE;
         it.port_sel = PORT_CTRL;
         it.write_data[CTRL_MODE_BIT] = 1'b0;
      end else if (roll < 85) begin
         it.req_type = KIND_WRITE;
         it.port_sel = PORT_CTRL;
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(it);
      n_sent++;
      @(negedge clock);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (120) @(negedge clock);
            hold_rsp  = 1'b0;
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = !quiet && ($urandom_range(99) < 14);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_image(rsp_data);
   end

   initial begin
      req_item_type script [$];
      req_item_type it;
      int           waited;
      sb = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      script.push_back(make_item(KIND_READ,  PORT_C,    8'h00, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_B,    8'h00, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_C,    8'hFF, 3'd0));
      script.push_back(make_item(KIND_KEY,   PORT_A,    8'hFE, 3'd0));
      script.push_back(make_item(KIND_KEY,   PORT_A,    8'h00, 3'd3));
      script.push_back(make_item(KIND_KEY,   PORT_A,    8'h7F, 3'd7));
      script.push_back(make_item(KIND_WRITE, PORT_A,    8'hFE, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_A,    8'h00, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_A,    8'h7F, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_A,    8'hFF, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_CTRL, 8'h0F, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_CTRL, 8'h00, 3'd0));
      script.push_back(make_item(KIND_READ,  PORT_A,    8'h00, 3'd0));
      script.push_back(make_item(KIND_READ,  PORT_B,    8'h00, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_CTRL, CTRL_MOUSE, 3'd0));
      it = make_item(KIND_MOUSE, PORT_A, 8'h00, 3'd0);
      it.mouse_x_pos = 16'sh7FFF;
      it.mouse_y_pos = 16'sh8000;
      it.mouse_keys  = 8'hFF;
      script.push_back(it);
      script.push_back(make_item(KIND_READ,  PORT_A,    8'h00, 3'd0));
      it.mouse_x_pos = 16'sh8000;
      it.mouse_y_pos = 16'sh7FFF;
      it.mouse_keys  = 8'h00;
      script.push_back(it);
      script.push_back(make_item(KIND_READ,  PORT_B,    8'h00, 3'd0));
      script.push_back(make_item(KIND_READ,  PORT_C,    8'h00, 3'd0));
      script.push_back(make_item(KIND_READ,  PORT_CTRL, 8'h00, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_CTRL, 8'h01, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_A,    8'h55, 3'd0));
      script.push_back(make_item(KIND_WRITE, PORT_CTRL, CTRL_KEYS, 3'd0));
      script.push_back(make_item(KIND_READ,  PORT_C,    8'h00, 3'd0));
      foreach (script[i]) send_item(script[i]);

      for (int k = 0; k < 1600; k++) begin
         quiet = (k >= 700 && k < 1000);
         if (k == 400) hold_rsp = 1'b1;
         if (k == 1100) begin
            // sender pause: let every outstanding image come back
            req_valid = 1'b0;
            while (sb.pending_images.size() != 0) @(negedge clock);
            repeat (4) @(negedge clock);
         end
         send_item(pick_item(k >= 400 && k < 430));
      end
      req_valid = 1'b0;

      waited = 0;
      while (sb.pending_images.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);

      if (sb.pending_images.size() != 0)
         $display("%0t: %0d expected images never arrived", $time, sb.pending_images.size());
      $display("run: %0d transactions sent, %0d port images compared, %0d mode writes",
               n_sent, sb.compared, sb.mode_writes);
      $display("run: key scans, mouse latches, port c bit set/reset, long output hold-off");
      if (sb.errors == 0 && sb.pending_images.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
